// ----- design/sdi_pkg.sv -----
// -----------------------------------------------------------------------------
// sdi_pkg
// Shared types and constants of the span depth interpolator.
// -----------------------------------------------------------------------------
`default_nettype none

package sdi_pkg;

   localparam int COORD_W  = 12;
   localparam int LEN_W    = 7;
   localparam int INDEX_W  = 24;
   localparam int DEPTH_W  = 16;
   localparam int ACC_W    = 32;
   localparam int PITCH_W  = 13;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 5;
   localparam int REG_SEL_W = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [REG_SEL_W-1:0] REG_ENABLE  = 3'd0;
   localparam logic [REG_SEL_W-1:0] REG_PITCH   = 3'd1;
   localparam logic [REG_SEL_W-1:0] REG_ORIGIN  = 3'd2;
   localparam logic [REG_SEL_W-1:0] REG_GRAD_X  = 3'd3;
   localparam logic [REG_SEL_W-1:0] REG_GRAD_Y  = 3'd4;
   localparam logic [REG_SEL_W-1:0] REG_STEP    = 3'd5;

   localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd1024;

   typedef struct packed {
      logic               enable;
      logic [PITCH_W-1:0] pitch;
      logic [ACC_W-1:0]   origin;
      logic [ACC_W-1:0]   grad_x;
      logic [ACC_W-1:0]   grad_y;
      logic [ACC_W-1:0]   step;
   } cfg_type;

   typedef struct packed {
      logic [ACC_W-1:0]   acc;
      logic [INDEX_W-1:0] index;
      logic [LEN_W-1:0]   len;
   } span_type;

endpackage

`default_nettype wire

// ----- design/sdi_if.sv -----
// -----------------------------------------------------------------------------
// sdi_req_if / sdi_rsp_if
// Valid/ready channels for spans in and pixels out.
// -----------------------------------------------------------------------------
`default_nettype none

interface sdi_req_if;
   import sdi_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] span_x;
   logic [COORD_W-1:0] span_y;
   logic [LEN_W-1:0]   span_length;

   modport source (output valid, output span_x, output span_y, output span_length,
                   input ready);
   modport sink   (input valid, input span_x, input span_y, input span_length,
                   output ready);
endinterface

interface sdi_rsp_if;
   import sdi_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [INDEX_W-1:0]        pixel_index;
   logic signed [DEPTH_W-1:0] depth_value;
   logic                      last_pixel;

   modport source (output valid, output pixel_index, output depth_value,
                   output last_pixel, input ready);
   modport sink   (input valid, input pixel_index, input depth_value,
                   input last_pixel, output ready);
endinterface

`default_nettype wire

// ----- design/sdi_front.sv -----
// -----------------------------------------------------------------------------
// sdi_front
// Accepts spans, drops empty or disabled ones, forms start depth and index.
// -----------------------------------------------------------------------------
`default_nettype none

module sdi_front #(
   parameter int MAX_SPAN   = 64,
   parameter int COORD_BITS = 12
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire sdi_pkg::cfg_type cfg,
   sdi_req_if.sink             req,
   output logic                push_valid,
   input  wire                 push_ready,
   output sdi_pkg::span_type   push_data
);
   import sdi_pkg::*;

   logic                  s1_valid_ff, s1_valid_in;
   logic [COORD_W-1:0]    x_ff;
   logic [ACC_W-1:0]      py_ff, px_ff;
   logic [INDEX_W-1:0]    pidx_ff;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [COORD_W-1:0]    x_m, y_m;
   logic                  req_fire, keep;

   assign req.ready = !s1_valid_ff || push_ready;
   assign req_fire  = req.valid && req.ready;
   assign x_m  = COORD_W'(req.span_x[COORD_BITS-1:0]);
   assign y_m  = COORD_W'(req.span_y[COORD_BITS-1:0]);
   assign keep = cfg.enable && (req.span_length != '0);
   assign len_in = (req.span_length > LEN_W'(MAX_SPAN)) ? LEN_W'(MAX_SPAN)
                                                         : req.span_length;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = keep;
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff    <= x_m;
         py_ff   <= ACC_W'(ACC_W'(y_m) * cfg.grad_y);
         px_ff   <= ACC_W'(ACC_W'(x_m) * cfg.grad_x);
         pidx_ff <= INDEX_W'(y_m) * INDEX_W'(cfg.pitch);
         len_ff  <= len_in;
      end
   end

   assign push_valid      = s1_valid_ff;
   assign push_data.acc   = cfg.origin + py_ff + px_ff;
   assign push_data.index = pidx_ff + INDEX_W'(x_ff);
   assign push_data.len   = len_ff;

endmodule

`default_nettype wire

// ----- design/sdi_queue.sv -----
// -----------------------------------------------------------------------------
// sdi_queue
// Short span queue between front and back end.
// -----------------------------------------------------------------------------
`default_nettype none

module sdi_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push_valid,
   output logic               push_ready,
   input  wire sdi_pkg::span_type push_data,
   output logic               pop_valid,
   input  wire                pop_ready,
   output sdi_pkg::span_type  pop_data
);
   import sdi_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   span_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push_fire, pop_fire;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push_fire && pop_fire) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_fire) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop_fire) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- design/sdi_back.sv -----
// -----------------------------------------------------------------------------
// sdi_back
// Walks a span into the result register, one pixel per cycle while not stalled.
// -----------------------------------------------------------------------------
`default_nettype none

module sdi_back #(
   parameter int MAX_SPAN = 64
) (
   input  wire                clock,
   input  wire                reset,
   input  wire sdi_pkg::cfg_type cfg,
   input  wire                pop_valid,
   output logic               pop_ready,
   input  wire sdi_pkg::span_type pop_data,
   sdi_rsp_if.source          rsp
);
   import sdi_pkg::*;

   localparam int REM_W = $clog2(MAX_SPAN + 1);

   logic                  active_ff;
   logic [ACC_W-1:0]      acc_ff;
   logic [INDEX_W-1:0]    idx_ff;
   logic [REM_W-1:0]      remain_ff;
   logic                  rsp_valid_ff;
   logic [INDEX_W-1:0]    rsp_index_ff;
   logic [DEPTH_W-1:0]    rsp_depth_ff;
   logic                  rsp_last_ff;
   logic                  emit, last_now, pop_fire;

   assign emit      = active_ff && (!rsp_valid_ff || rsp.ready);
   assign last_now  = remain_ff == REM_W'(1);
   assign pop_ready = !active_ff || (emit && last_now);
   assign pop_fire  = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop_fire) begin
            active_ff <= 1'b1;
         end else if (emit && last_now) begin
            active_ff <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         acc_ff    <= pop_data.acc;
         idx_ff    <= pop_data.index;
         remain_ff <= REM_W'(pop_data.len);
      end else if (emit) begin
         acc_ff    <= acc_ff + cfg.step;
         idx_ff    <= idx_ff + INDEX_W'(1);
         remain_ff <= remain_ff - REM_W'(1);
      end
      if (emit) begin
         rsp_index_ff <= idx_ff;
         rsp_depth_ff <= acc_ff[ACC_W-1 -: DEPTH_W];
         rsp_last_ff  <= last_now;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pixel_index = rsp_index_ff;
   assign rsp.depth_value = rsp_depth_ff;
   assign rsp.last_pixel  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- design/span_depth_interpolator_core.sv -----
// -----------------------------------------------------------------------------
// span_depth_interpolator_core
// Scanline inverse-depth interpolation: one span in, one result per pixel out.
// -----------------------------------------------------------------------------
//  channel  direction  carries
//  req      in         span_x, span_y, span_length
//  rsp      out        pixel_index, depth_value, last_pixel
//  csr      in/out     APB register port, six registers at 4*i
//
//  A span passes the front's product registers (sums formed on the way in), a
//  queue entry, the back end's walk registers and the rsp result register. The
//  back end emits one pixel per cycle while rsp is not stalled; that pixel loop
//  sets the sustained rate. Empty or disabled spans are dropped at the front.
//  Reset is synchronous and resets handshake state and config; no clearing pass.
//  A stalled rsp holds its item; the queue lets the front take spans until full.
// -----------------------------------------------------------------------------
`default_nettype none

module span_depth_interpolator_core #(
   parameter int MAX_SPAN   = 64,
   parameter int COORD_BITS = 12
) (
   input  wire                          clock,
   input  wire                          reset,
   sdi_req_if.sink                      req,
   sdi_rsp_if.source                    rsp,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [sdi_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire  [sdi_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [sdi_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import sdi_pkg::*;

   cfg_type               cfg_ff;
   logic [REG_SEL_W-1:0]  sel;
   logic                  wr_en;
   logic                  push_valid, push_ready, pop_valid, pop_ready;
   span_type              push_data, pop_data;

   assign csr_pready = 1'b1;
   assign sel   = csr_paddr[ADDR_W-1:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable <= 1'b1;
         cfg_ff.pitch  <= PITCH_RESET;
         cfg_ff.origin <= '0;
         cfg_ff.grad_x <= '0;
         cfg_ff.grad_y <= '0;
         cfg_ff.step   <= '0;
      end else if (wr_en) begin
         unique case (sel)
            REG_ENABLE: cfg_ff.enable <= csr_pwdata[0];
            REG_PITCH:  cfg_ff.pitch  <= csr_pwdata[PITCH_W-1:0];
            REG_ORIGIN: cfg_ff.origin <= csr_pwdata;
            REG_GRAD_X: cfg_ff.grad_x <= csr_pwdata;
            REG_GRAD_Y: cfg_ff.grad_y <= csr_pwdata;
            REG_STEP:   cfg_ff.step   <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_ENABLE: csr_prdata = DATA_W'(cfg_ff.enable);
         REG_PITCH:  csr_prdata = DATA_W'(cfg_ff.pitch);
         REG_ORIGIN: csr_prdata = cfg_ff.origin;
         REG_GRAD_X: csr_prdata = cfg_ff.grad_x;
         REG_GRAD_Y: csr_prdata = cfg_ff.grad_y;
         REG_STEP:   csr_prdata = cfg_ff.step;
         default:    csr_prdata = '0;
      endcase
   end

   sdi_front #(
      .MAX_SPAN   (MAX_SPAN),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   sdi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   sdi_back #(
      .MAX_SPAN (MAX_SPAN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

// ----- design/sdi_checker.sv -----
// -----------------------------------------------------------------------------
// sdi_checker
// Port-level checks on the span depth interpolator.
// -----------------------------------------------------------------------------
`default_nettype none

module sdi_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [sdi_pkg::INDEX_W-1:0]   rsp_pixel_index,
   input wire [sdi_pkg::DEPTH_W-1:0]   rsp_depth_value,
   input wire                          rsp_last_pixel,
   input wire                          csr_pready
);
   import sdi_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_index)
         && $stable(rsp_depth_value) && $stable(rsp_last_pixel))
      else $error("rsp item changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr_pready low");

   a_next_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_pixel |=>
         rsp_valid && (rsp_pixel_index == $past(rsp_pixel_index) + INDEX_W'(1)))
      else $error("pixel within a span missing or out of order");

endmodule

bind span_depth_interpolator_core sdi_checker u_sdi_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_pixel_index (rsp.pixel_index),
   .rsp_depth_value (rsp.depth_value),
   .rsp_last_pixel  (rsp.last_pixel),
   .csr_pready      (csr_pready)
);

`default_nettype wire
